FILE: design/tpsa_pkg.sv
// tpsa_pkg: shared types and constants of the three-pool slot allocator
// no dependencies; used by the interfaces and imported by every design module
package tpsa_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int POOL_W     = 2;
    localparam int SLOT_W     = 7;
    localparam int CFG_IDX_W  = 2;

    // free-slot search works on groups of this many busy bits
    localparam int GROUP_W    = 32;
    localparam int GROUP_BITS = 5;

    localparam int SMALL_SHIFT  = 8;
    localparam int MEDIUM_SHIFT = 12;
    localparam int LARGE_SHIFT  = 21;

    localparam logic [SIZE_W-1:0] SMALL_BYTES  = 32'd256;
    localparam logic [SIZE_W-1:0] MEDIUM_BYTES = 32'd4096;
    localparam logic [SIZE_W-1:0] LARGE_BYTES  = 32'd2097152;

    localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 48'h0000_0010_0000;
    localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 48'h0000_0020_0000;
    localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 48'h0000_0040_0000;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_ZERO        = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_NOT_IN_POOL = 3'd4,
        ST_DOUBLE_FREE = 3'd5
    } status_t;

    typedef enum logic [POOL_W-1:0] {
        NO_POOL     = 2'd0,
        SMALL_POOL  = 2'd1,
        MEDIUM_POOL = 2'd2,
        LARGE_POOL  = 2'd3
    } pool_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_BASE  = 2'd0,
        CFG_MEDIUM_BASE = 2'd1,
        CFG_LARGE_BASE  = 2'd2
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    // datapath to one pool
    typedef struct packed {
        logic alloc;
        logic free;
    } pool_cmd_t;

    // one pool back to the datapath
    typedef struct packed {
        logic found;
        logic free_busy;
    } pool_stat_t;

endpackage

FILE: design/tpsa_req_if.sv
// tpsa_req_if: request channel of the slot allocator
// depends on tpsa_pkg
interface tpsa_req_if;
    logic                            valid;
    logic                            ready;
    tpsa_pkg::cmd_t                  cmd;
    logic [tpsa_pkg::SIZE_W-1:0]     request_size;
    logic [tpsa_pkg::ADDR_W-1:0]     free_address;

    modport source (output valid, cmd, request_size, free_address, input ready);
    modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface

FILE: design/tpsa_rsp_if.sv
// tpsa_rsp_if: result channel of the slot allocator
// depends on tpsa_pkg
interface tpsa_rsp_if;
    logic                            valid;
    logic                            ready;
    tpsa_pkg::status_t               status;
    logic [tpsa_pkg::ADDR_W-1:0]     granted_address;
    tpsa_pkg::pool_t                 pool_used;
    logic [tpsa_pkg::SLOT_W-1:0]     slot_index;

    modport source (output valid, status, granted_address, pool_used, slot_index,
                    input ready);
    modport sink   (input valid, status, granted_address, pool_used, slot_index,
                    output ready);
endinterface

FILE: design/tpsa_cfg_if.sv
// tpsa_cfg_if: register write channel of the slot allocator
// depends on tpsa_pkg
interface tpsa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpsa_pkg::CFG_IDX_W-1:0]  index;
    logic [tpsa_pkg::ADDR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tpsa_pool.sv
// tpsa_pool: busy bitmap, recently-freed list and free-slot search of one pool
// depends on tpsa_pkg
module tpsa_pool #(
    parameter int  SLOTS        = 128,
    parameter int  RECENT_DEPTH = 4,
    localparam int IW           = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpsa_pkg::pool_cmd_t   cmd,
    input  logic [IW-1:0]         free_idx,
    output tpsa_pkg::pool_stat_t  stat,
    output logic [IW-1:0]         grant_idx
);
    import tpsa_pkg::*;

    localparam int NG   = (SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int PADW = NG * GROUP_W;
    localparam int RSW  = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

    logic [SLOTS-1:0]        busy_reg, busy_next;
    logic [RECENT_DEPTH-1:0] rvalid_reg, rvalid_next;
    logic [IW-1:0]           ridx_reg  [RECENT_DEPTH];
    logic [IW-1:0]           ridx_next [RECENT_DEPTH];
    logic [NG-1:0]           gfree_reg, gfree_next;
    logic [GROUP_BITS-1:0]   goff_reg  [NG];
    logic [GROUP_BITS-1:0]   goff_next [NG];
    logic [PADW-1:0]         busy_pad;

    logic                    rec_found, tree_found, emp_found;
    logic [RSW-1:0]          rec_sel, emp_sel;
    logic [IW-1:0]           rec_idx, tree_idx;

    // first level of the search: lowest free bit in each group, refreshed every cycle
    always_comb
    begin
        busy_pad             = '1;
        busy_pad[SLOTS-1:0]  = busy_reg;
        for (int g = 0; g < NG; g++)
        begin
            gfree_next[g] = 1'b0;
            goff_next[g]  = '0;
            for (int b = GROUP_W - 1; b >= 0; b--)
            begin
                if (!busy_pad[g*GROUP_W + b])
                begin
                    gfree_next[g] = 1'b1;
                    goff_next[g]  = GROUP_BITS'(b);
                end
            end
        end
    end

    // second level: lowest group with a free bit, and the recent list
    always_comb
    begin
        tree_found = 1'b0;
        tree_idx   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (gfree_reg[g])
            begin
                tree_found = 1'b1;
                tree_idx   = IW'(g*GROUP_W + int'(goff_reg[g]));
            end
        end

        rec_found = 1'b0;
        rec_sel   = '0;
        rec_idx   = '0;
        emp_found = 1'b0;
        emp_sel   = '0;
        for (int i = RECENT_DEPTH - 1; i >= 0; i--)
        begin
            if (rvalid_reg[i])
            begin
                rec_found = 1'b1;
                rec_sel   = RSW'(i);
                rec_idx   = ridx_reg[i];
            end
            else
            begin
                emp_found = 1'b1;
                emp_sel   = RSW'(i);
            end
        end
    end

    assign grant_idx      = rec_found ? rec_idx : tree_idx;
    assign stat.found     = rec_found | tree_found;
    assign stat.free_busy = busy_reg[free_idx];

    always_comb
    begin
        busy_next   = busy_reg;
        rvalid_next = rvalid_reg;
        ridx_next   = ridx_reg;
        if (cmd.alloc)
        begin
            busy_next[grant_idx] = 1'b1;
            if (rec_found)
            begin
                rvalid_next[rec_sel] = 1'b0;
            end
        end
        if (cmd.free)
        begin
            busy_next[free_idx] = 1'b0;
            // dropped when the list is full
            if (emp_found)
            begin
                rvalid_next[emp_sel] = 1'b1;
                ridx_next[emp_sel]   = free_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            rvalid_reg <= '0;
            gfree_reg  <= '1;
            for (int g = 0; g < NG; g++)
            begin
                goff_reg[g] <= '0;
            end
        end
        else
        begin
            busy_reg   <= busy_next;
            rvalid_reg <= rvalid_next;
            gfree_reg  <= gfree_next;
            goff_reg   <= goff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
    end

endmodule

FILE: design/tpsa_datapath.sv
// tpsa_datapath: base registers, request decode, pool lookup and result register
// depends on tpsa_pkg and tpsa_pool
module tpsa_datapath #(
    parameter int SMALL_SLOTS  = 128,
    parameter int MEDIUM_SLOTS = 32,
    parameter int LARGE_SLOTS  = 16,
    parameter int RECENT_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpsa_pkg::ctrl_cmd_t               ctrl,
    input  tpsa_pkg::cmd_t                    cmd,
    input  logic [tpsa_pkg::SIZE_W-1:0]       request_size,
    input  logic [tpsa_pkg::ADDR_W-1:0]       free_address,
    input  logic                              cfg_write,
    input  logic [tpsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpsa_pkg::ADDR_W-1:0]       cfg_data,
    output tpsa_pkg::status_t                 status,
    output logic [tpsa_pkg::ADDR_W-1:0]       granted_address,
    output tpsa_pkg::pool_t                   pool_used,
    output logic [tpsa_pkg::SLOT_W-1:0]       slot_index
);
    import tpsa_pkg::*;

    localparam int S_IW = (SMALL_SLOTS > 1)  ? $clog2(SMALL_SLOTS)  : 1;
    localparam int M_IW = (MEDIUM_SLOTS > 1) ? $clog2(MEDIUM_SLOTS) : 1;
    localparam int L_IW = (LARGE_SLOTS > 1)  ? $clog2(LARGE_SLOTS)  : 1;

    localparam logic [ADDR_W-1:0] SMALL_SPAN  = ADDR_W'(SMALL_SLOTS)  << SMALL_SHIFT;
    localparam logic [ADDR_W-1:0] MEDIUM_SPAN = ADDR_W'(MEDIUM_SLOTS) << MEDIUM_SHIFT;
    localparam logic [ADDR_W-1:0] LARGE_SPAN  = ADDR_W'(LARGE_SLOTS)  << LARGE_SHIFT;

    logic [ADDR_W-1:0] sbase_reg, sbase_next;
    logic [ADDR_W-1:0] mbase_reg, mbase_next;
    logic [ADDR_W-1:0] lbase_reg, lbase_next;

    // request held for the search-and-commit step
    cmd_t              cmd_reg;
    logic              zero_reg, big_reg;
    pool_t             psel_reg, psel_next;
    logic [2:0]        hit_reg, hit_next;
    logic [S_IW-1:0]   sidx_reg;
    logic [M_IW-1:0]   midx_reg;
    logic [L_IW-1:0]   lidx_reg;

    logic [ADDR_W:0]   sdiff, mdiff, ldiff;

    pool_cmd_t         s_cmd, m_cmd, l_cmd;
    pool_stat_t        s_stat, m_stat, l_stat;
    logic [S_IW-1:0]   s_grant;
    logic [M_IW-1:0]   m_grant;
    logic [L_IW-1:0]   l_grant;

    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] grant_reg, grant_next;
    pool_t             pool_reg, pool_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [ADDR_W-1:0] sum_base, sum_off;
    pool_t             fpool;

    always_comb
    begin
        sbase_next = sbase_reg;
        mbase_next = mbase_reg;
        lbase_next = lbase_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SMALL_BASE:  sbase_next = cfg_data;
                CFG_MEDIUM_BASE: mbase_next = cfg_data;
                CFG_LARGE_BASE:  lbase_next = cfg_data;
                default:         sbase_next = sbase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbase_reg <= SMALL_BASE_RST;
            mbase_reg <= MEDIUM_BASE_RST;
            lbase_reg <= LARGE_BASE_RST;
        end
        else
        begin
            sbase_reg <= sbase_next;
            mbase_reg <= mbase_next;
            lbase_reg <= lbase_next;
        end
    end

    // load step: size class and range check against each pool
    assign sdiff = {1'b0, free_address} - {1'b0, sbase_reg};
    assign mdiff = {1'b0, free_address} - {1'b0, mbase_reg};
    assign ldiff = {1'b0, free_address} - {1'b0, lbase_reg};

    always_comb
    begin
        hit_next[0] = !sdiff[ADDR_W] && (sdiff[ADDR_W-1:0] < SMALL_SPAN);
        hit_next[1] = !mdiff[ADDR_W] && (mdiff[ADDR_W-1:0] < MEDIUM_SPAN);
        hit_next[2] = !ldiff[ADDR_W] && (ldiff[ADDR_W-1:0] < LARGE_SPAN);
        // address zero never frees anything
        if (free_address == '0)
        begin
            hit_next = '0;
        end

        if (request_size <= SMALL_BYTES)
        begin
            psel_next = SMALL_POOL;
        end
        else if (request_size <= MEDIUM_BYTES)
        begin
            psel_next = MEDIUM_POOL;
        end
        else
        begin
            psel_next = LARGE_POOL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            zero_reg <= (request_size == '0);
            big_reg  <= (request_size > LARGE_BYTES);
            psel_reg <= psel_next;
            hit_reg  <= hit_next;
            sidx_reg <= S_IW'(sdiff[ADDR_W-1:0] >> SMALL_SHIFT);
            midx_reg <= M_IW'(mdiff[ADDR_W-1:0] >> MEDIUM_SHIFT);
            lidx_reg <= L_IW'(ldiff[ADDR_W-1:0] >> LARGE_SHIFT);
        end
    end

    tpsa_pool #(.SLOTS(SMALL_SLOTS), .RECENT_DEPTH(RECENT_DEPTH)) u_small (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (s_cmd),
        .free_idx  (sidx_reg),
        .stat      (s_stat),
        .grant_idx (s_grant)
    );

    tpsa_pool #(.SLOTS(MEDIUM_SLOTS), .RECENT_DEPTH(RECENT_DEPTH)) u_medium (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (m_cmd),
        .free_idx  (midx_reg),
        .stat      (m_stat),
        .grant_idx (m_grant)
    );

    tpsa_pool #(.SLOTS(LARGE_SLOTS), .RECENT_DEPTH(RECENT_DEPTH)) u_large (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (l_cmd),
        .free_idx  (lidx_reg),
        .stat      (l_stat),
        .grant_idx (l_grant)
    );

    // commit step: pick the outcome, commit the pool update, load the result
    always_comb
    begin
        status_next = ST_OK;
        pool_next   = NO_POOL;
        slot_next   = '0;
        sum_base    = '0;
        sum_off     = '0;
        s_cmd       = '0;
        m_cmd       = '0;
        l_cmd       = '0;
        fpool       = NO_POOL;

        if (hit_reg[0])
        begin
            fpool = SMALL_POOL;
        end
        else if (hit_reg[1])
        begin
            fpool = MEDIUM_POOL;
        end
        else if (hit_reg[2])
        begin
            fpool = LARGE_POOL;
        end

        if (cmd_reg == CMD_ALLOC)
        begin
            if (zero_reg)
            begin
                status_next = ST_ZERO;
            end
            else if (big_reg)
            begin
                status_next = ST_TOO_LARGE;
            end
            else
            begin
                pool_next   = psel_reg;
                status_next = ST_EXHAUSTED;
                case (psel_reg)
                    SMALL_POOL:
                    begin
                        if (s_stat.found)
                        begin
                            status_next = ST_OK;
                            slot_next   = SLOT_W'(s_grant);
                            sum_base    = sbase_reg;
                            sum_off     = ADDR_W'(s_grant) << SMALL_SHIFT;
                            s_cmd.alloc = ctrl.commit;
                        end
                    end
                    MEDIUM_POOL:
                    begin
                        if (m_stat.found)
                        begin
                            status_next = ST_OK;
                            slot_next   = SLOT_W'(m_grant);
                            sum_base    = mbase_reg;
                            sum_off     = ADDR_W'(m_grant) << MEDIUM_SHIFT;
                            m_cmd.alloc = ctrl.commit;
                        end
                    end
                    LARGE_POOL:
                    begin
                        if (l_stat.found)
                        begin
                            status_next = ST_OK;
                            slot_next   = SLOT_W'(l_grant);
                            sum_base    = lbase_reg;
                            sum_off     = ADDR_W'(l_grant) << LARGE_SHIFT;
                            l_cmd.alloc = ctrl.commit;
                        end
                    end
                    default:
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                endcase
            end
        end
        else
        begin
            pool_next   = fpool;
            status_next = ST_NOT_IN_POOL;
            case (fpool)
                SMALL_POOL:
                begin
                    slot_next   = SLOT_W'(sidx_reg);
                    status_next = s_stat.free_busy ? ST_OK : ST_DOUBLE_FREE;
                    s_cmd.free  = ctrl.commit & s_stat.free_busy;
                end
                MEDIUM_POOL:
                begin
                    slot_next   = SLOT_W'(midx_reg);
                    status_next = m_stat.free_busy ? ST_OK : ST_DOUBLE_FREE;
                    m_cmd.free  = ctrl.commit & m_stat.free_busy;
                end
                LARGE_POOL:
                begin
                    slot_next   = SLOT_W'(lidx_reg);
                    status_next = l_stat.free_busy ? ST_OK : ST_DOUBLE_FREE;
                    l_cmd.free  = ctrl.commit & l_stat.free_busy;
                end
                default:
                begin
                    status_next = ST_NOT_IN_POOL;
                end
            endcase
        end

        // wraps to 48 bits
        grant_next = sum_base + sum_off;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            pool_reg   <= pool_next;
            slot_reg   <= slot_next;
        end
    end

    assign status          = status_reg;
    assign granted_address = grant_reg;
    assign pool_used       = pool_reg;
    assign slot_index      = slot_reg;

endmodule

FILE: design/tpsa_ctrl.sv
// tpsa_ctrl: request sequencing and result-register occupancy
// depends on tpsa_pkg
module tpsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpsa_pkg::ctrl_cmd_t  ctrl
);
    import tpsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit;

    // the commit step completes once the result register is free or draining
    assign commit      = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready    = (state_reg == S_IDLE);
    assign ctrl.load   = (state_reg == S_IDLE) && in_valid;
    assign ctrl.commit = commit;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/three_pool_slot_allocator.sv
// three_pool_slot_allocator: top level of the fixed-size slot allocator
// depends on tpsa_pkg, the three channel interfaces, tpsa_ctrl and tpsa_datapath
//
//  channel  dir  payload                                          flow
//  req      in   cmd, request_size, free_address                  valid/ready
//  rsp      out  status, granted_address, pool_used, slot_index   valid/ready
//  cfg      in   index, data (pool base addresses)                valid/ready, always ready
//
// each request passes through two steps: accept, then search-and-commit in the pools
// a new request is taken in the cycle after the commit, so requests never overlap
// the commit waits while the result register still holds an untaken result
// the free-slot search is a two-level tree: group summaries refresh every cycle
// reset frees every slot, empties the recently-freed lists and restores the bases
module three_pool_slot_allocator #(
    parameter int SMALL_SLOTS  = 128,
    parameter int MEDIUM_SLOTS = 32,
    parameter int LARGE_SLOTS  = 16,
    parameter int RECENT_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    tpsa_req_if.sink     req,
    tpsa_rsp_if.source   rsp,
    tpsa_cfg_if.sink     cfg
);
    import tpsa_pkg::*;

    ctrl_cmd_t ctrl;

    assign cfg.ready = 1'b1;

    tpsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    tpsa_datapath #(
        .SMALL_SLOTS  (SMALL_SLOTS),
        .MEDIUM_SLOTS (MEDIUM_SLOTS),
        .LARGE_SLOTS  (LARGE_SLOTS),
        .RECENT_DEPTH (RECENT_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .cmd             (req.cmd),
        .request_size    (req.request_size),
        .free_address    (req.free_address),
        .cfg_write       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .status          (rsp.status),
        .granted_address (rsp.granted_address),
        .pool_used       (rsp.pool_used),
        .slot_index      (rsp.slot_index)
    );

endmodule
